// ===== rtl/stcl_pkg.sv =====
// ----------------------------------------------------------------------------
// stcl_pkg: shared types and constants for the sample-to-chunk lookup
// Table geometry, action and status codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package stcl_pkg;

  localparam int MAX_RUNS = 256;
  localparam int IDX_W    = $clog2(MAX_RUNS);
  localparam int CNT_W    = $clog2(MAX_RUNS + 1);

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] first_chunk;
    logic [31:0] samples;
    logic [31:0] description;
    logic [31:0] start_sample;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;       // capture request fields
    logic    cnt_clear;
    logic    rd_en;
    logic    rd_init;    // 1: read last entry, 0: read entry below scan pointer
    logic    wr_en;      // append entry at run_count
    logic    div_start;
    logic    mul_en;
    logic    mul_query;  // 1: quotient * samples, 0: chunk delta * samples
    logic    res_load;
    logic    res_fields; // drive lookup fields, else zeros
    status_e status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_e action;
    logic    cnt_zero;
    logic    cnt_full;
    logic    fc_zero;
    logic    spc_zero;
    logic    fc_not_incr;
    logic    hit;
    logic    div_done;
  } sts_t;

endpackage

// ===== rtl/stcl_div.sv =====
// ----------------------------------------------------------------------------
// stcl_div: 32-bit unsigned restoring divider
// One quotient bit per cycle; done pulses when the quotient is valid.
// ----------------------------------------------------------------------------
module stcl_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [31:0] quotient_o,
  output logic        done_o
);

  logic [31:0]                   rem_q, quo_q, dvs_q;
  logic [stcl_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          run_q, done_q;
  logic [32:0]                   shifted;
  logic [33:0]                   diff;

  assign shifted = {rem_q, quo_q[31]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= stcl_pkg::DIV_CNT_W'(stcl_pkg::DIV_STEPS);
      end else if (run_q) begin
        cnt_q <= cnt_q - stcl_pkg::DIV_CNT_W'(1);
        if (cnt_q == stcl_pkg::DIV_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      if (!diff[33]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ===== rtl/stcl_dp.sv =====
// ----------------------------------------------------------------------------
// stcl_dp: run table datapath
// Table memory, run count, scan pointer, shared multiplier, divider and
// result registers.
// ----------------------------------------------------------------------------
module stcl_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             action_i,
  input  logic [31:0]            first_chunk_i,
  input  logic [31:0]            samples_per_chunk_i,
  input  logic [31:0]            desc_index_i,
  input  logic [31:0]            sample_number_i,
  input  stcl_pkg::cmd_t         cmd_i,
  output stcl_pkg::sts_t         sts_o,
  output logic [1:0]             status_o,
  output logic [31:0]            chunk_index_o,
  output logic [31:0]            chunk_first_sample_o,
  output logic [31:0]            result_desc_index_o
);

  localparam int IDX_W = stcl_pkg::IDX_W;
  localparam int CNT_W = stcl_pkg::CNT_W;

  stcl_pkg::entry_t mem [stcl_pkg::MAX_RUNS];
  stcl_pkg::entry_t rd_q, wr_data;

  stcl_pkg::action_e action_q;
  logic [31:0] fc_q, spc_q, desc_q, n_q;
  logic [CNT_W-1:0] cnt_q, cnt_m1;
  logic [IDX_W-1:0] scan_q, rd_addr;
  logic [31:0] prod_q, mul_a, quotient;
  logic [63:0] mul_full;
  logic        div_done;

  logic [1:0]  status_q;
  logic [31:0] chunk_q, first_q, desc_res_q;

  assign cnt_m1  = cnt_q - CNT_W'(1);
  assign rd_addr = cmd_i.rd_init ? cnt_m1[IDX_W-1:0] : scan_q - IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clear) begin
      cnt_q <= '0;
    end else if (cmd_i.wr_en) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= stcl_pkg::action_e'(action_i);
      fc_q     <= first_chunk_i;
      spc_q    <= samples_per_chunk_i;
      desc_q   <= desc_index_i;
      n_q      <= sample_number_i;
    end
    if (cmd_i.rd_en) begin
      scan_q <= rd_addr;
    end
  end

  // first entry always starts at sample zero
  always_comb begin
    wr_data.first_chunk  = fc_q;
    wr_data.samples      = spc_q;
    wr_data.description  = desc_q;
    wr_data.start_sample = (cnt_q == '0) ? 32'd0 : rd_q.start_sample + prod_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cnt_q[IDX_W-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  stcl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (n_q - rd_q.start_sample),
    .divisor_i  (rd_q.samples),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign mul_a    = cmd_i.mul_query ? quotient : fc_q - rd_q.first_chunk;
  assign mul_full = mul_a * rd_q.samples;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_full[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q <= cmd_i.status;
      if (cmd_i.res_fields) begin
        chunk_q    <= rd_q.first_chunk - 32'd1 + quotient;
        first_q    <= rd_q.start_sample + prod_q;
        desc_res_q <= rd_q.description;
      end else begin
        chunk_q    <= '0;
        first_q    <= '0;
        desc_res_q <= '0;
      end
    end
  end

  always_comb begin
    sts_o.action      = action_q;
    sts_o.cnt_zero    = (cnt_q == '0);
    sts_o.cnt_full    = (cnt_q == CNT_W'(stcl_pkg::MAX_RUNS));
    sts_o.fc_zero     = (fc_q == '0);
    sts_o.spc_zero    = (spc_q == '0);
    sts_o.fc_not_incr = (fc_q <= rd_q.first_chunk);
    sts_o.hit         = (rd_q.start_sample <= n_q) || (scan_q == '0);
    sts_o.div_done    = div_done;
  end

  assign status_o             = status_q;
  assign chunk_index_o        = chunk_q;
  assign chunk_first_sample_o = first_q;
  assign result_desc_index_o  = desc_res_q;

endmodule

// ===== rtl/stcl_ctrl.sv =====
// ----------------------------------------------------------------------------
// stcl_ctrl: request sequencer
// Decodes the action, walks the table from the top for queries and steps the
// append and lookup arithmetic.
// ----------------------------------------------------------------------------
module stcl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  stcl_pkg::sts_t sts_i,
  output stcl_pkg::cmd_t cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_AP_MUL,
    S_AP_WR,
    S_Q_SCAN,
    S_Q_DIV,
    S_Q_OUT
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d        = S_IDLE;
        cmd_o.res_load = 1'b1;
        cmd_o.status   = stcl_pkg::ST_OK;
        case (sts_i.action)
          stcl_pkg::ACT_CLEAR: begin
            cmd_o.cnt_clear = 1'b1;
          end
          stcl_pkg::ACT_APPEND: begin
            if (sts_i.cnt_full) begin
              cmd_o.status = stcl_pkg::ST_FULL;
            end else if (sts_i.fc_zero || sts_i.spc_zero) begin
              cmd_o.status = stcl_pkg::ST_BAD;
            end else if (sts_i.cnt_zero) begin
              cmd_o.wr_en = 1'b1;
            end else begin
              cmd_o.res_load = 1'b0;
              cmd_o.rd_en    = 1'b1;
              cmd_o.rd_init  = 1'b1;
              state_d        = S_AP_MUL;
            end
          end
          stcl_pkg::ACT_QUERY: begin
            if (sts_i.cnt_zero) begin
              cmd_o.status = stcl_pkg::ST_EMPTY;
            end else begin
              cmd_o.res_load = 1'b0;
              cmd_o.rd_en    = 1'b1;
              cmd_o.rd_init  = 1'b1;
              state_d        = S_Q_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_AP_MUL: begin
        if (sts_i.fc_not_incr) begin
          cmd_o.res_load = 1'b1;
          cmd_o.status   = stcl_pkg::ST_BAD;
          state_d        = S_IDLE;
        end else begin
          cmd_o.mul_en = 1'b1;
          state_d      = S_AP_WR;
        end
      end
      S_AP_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.status   = stcl_pkg::ST_OK;
        state_d        = S_IDLE;
      end
      S_Q_SCAN: begin
        // read data stays put on a hit and feeds the divider
        if (sts_i.hit) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_Q_DIV;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      S_Q_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.mul_en    = 1'b1;
          cmd_o.mul_query = 1'b1;
          state_d         = S_Q_OUT;
        end
      end
      S_Q_OUT: begin
        cmd_o.mul_query  = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_fields = 1'b1;
        cmd_o.status     = stcl_pkg::ST_OK;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.res_load;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== rtl/sample_to_chunk_lookup.sv =====
// ----------------------------------------------------------------------------
// sample_to_chunk_lookup: sample-to-chunk run table with sample lookup
// Clear, append and query requests against a table of up to 256 runs.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; every request
// gives exactly one result, shown for one cycle with done_o high, and the
// receiver must take it then. Clear, the unused action, appends to a full
// table, appends with a zero field and appends or queries to an empty table
// are answered from the decode state; an append whose first chunk does not
// increase is answered after the read of the previous run, and a good append
// to a non-empty table steps through that read, multiply and write. A query
// reads from one up to run-count runs from the top of the table until one
// starts at or below the sample, then runs the one-bit-per-cycle divider and
// a multiply. A new request can be taken in the cycle the result is shown.
// ----------------------------------------------------------------------------
module sample_to_chunk_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] first_chunk_i,
  input  logic [31:0] samples_per_chunk_i,
  input  logic [31:0] desc_index_i,
  input  logic [31:0] sample_number_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] chunk_index_o,
  output logic [31:0] chunk_first_sample_o,
  output logic [31:0] result_desc_index_o
);

  stcl_pkg::cmd_t cmd;
  stcl_pkg::sts_t sts;

  stcl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  stcl_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .action_i             (action_i),
    .first_chunk_i        (first_chunk_i),
    .samples_per_chunk_i  (samples_per_chunk_i),
    .desc_index_i         (desc_index_i),
    .sample_number_i      (sample_number_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .status_o             (status_o),
    .chunk_index_o        (chunk_index_o),
    .chunk_first_sample_o (chunk_first_sample_o),
    .result_desc_index_o  (result_desc_index_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while a request is still in progress");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != stcl_pkg::ST_OK) |->
      (chunk_index_o == '0 && chunk_first_sample_o == '0 &&
       result_desc_index_o == '0))
    else $error("error result carries nonzero fields");

endmodule
